[rtl/core/pmsq_pkg.sv]
// ----------------------------------------------------------------------------
// Priority message slot queue package
// Shared sizes, codes and types of the slot queue: slot word layout, status
// codes, command codes, configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
package pmsq_pkg;

    // Storage geometry.
    localparam int SLOT_COUNT      = 256;
    localparam int PRIORITY_LEVELS = 32768;
    localparam int PAYLOAD_BITS    = 64;

    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int PRIO_W = $clog2(PRIORITY_LEVELS);
    localparam int LEN_W  = 17;
    localparam int SEQ_W  = 64;
    localparam int MODE_W = 2;
    localparam int CAPR_W = 9;

    localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(SLOT_COUNT);

    // Configuration limits and reset values.
    localparam int SIZE_LIMIT = 65536;
    localparam logic [CAPR_W-1:0] CAP_RESET  = CAPR_W'(10);
    localparam logic [LEN_W-1:0]  SIZE_RESET = LEN_W'(8192);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_MESSAGES = 2'd0,
        CFG_MESSAGE_SIZE = 2'd1,
        CFG_ACCESS_MODE  = 2'd2
    } t_cfg_index;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ_ONLY  = 2'd0,
        MODE_WRITE_ONLY = 2'd1,
        MODE_READ_WRITE = 2'd2
    } t_mode;

    typedef enum logic {
        CMD_SEND    = 1'b0,
        CMD_RECEIVE = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_ACCESS   = 3'd1,
        STS_SIZE     = 3'd2,
        STS_PRIORITY = 3'd3,
        STS_FULL     = 3'd4,
        STS_EMPTY    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEND_SCAN,
        ST_RECV_SCAN,
        ST_RECV_TAKE
    } t_state;

    // One slot entry as held in the slot memory.
    typedef struct packed {
        logic [PRIO_W-1:0]       prio;
        logic [LEN_W-1:0]        len;
        logic [SEQ_W-1:0]        seq;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_slot_word;

    // Candidate slot presented to the compare unit along with its read data.
    typedef struct packed {
        logic             vld;
        logic             used;
        logic [IDX_W-1:0] idx;
    } t_cand;

    // Best slot found so far by the compare unit.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_best;

endpackage

[rtl/core/pmsq_slot_ram.sv]
// ----------------------------------------------------------------------------
// Slot memory
// One write port and one read port with registered read data, holding the
// priority, length, sequence number and payload word of every slot.
// ----------------------------------------------------------------------------
module pmsq_slot_ram (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [pmsq_pkg::IDX_W-1:0]       i_wr_addr,
    input  pmsq_pkg::t_slot_word             i_wr_data,
    input  logic [pmsq_pkg::IDX_W-1:0]       i_rd_addr,
    output pmsq_pkg::t_slot_word             o_rd_data
);

    pmsq_pkg::t_slot_word r_mem [pmsq_pkg::SLOT_COUNT];
    pmsq_pkg::t_slot_word r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data registered.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/pmsq_select.sv]
// ----------------------------------------------------------------------------
// Best slot compare unit
// Takes one slot per cycle and keeps the used slot with the highest priority,
// the lowest sequence number winning on equal priority.
// ----------------------------------------------------------------------------
module pmsq_select (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  pmsq_pkg::t_cand      i_cand,
    input  pmsq_pkg::t_slot_word i_word,
    output pmsq_pkg::t_best      o_best,
    output pmsq_pkg::t_slot_word o_best_word
);

    logic                          r_found;
    logic [pmsq_pkg::IDX_W-1:0]    r_idx;
    pmsq_pkg::t_slot_word          r_word;
    logic                          better;

    // The candidate wins if nothing is held yet, its priority is higher, or
    // the priorities match and it is the older message.
    always_comb begin
        better = i_cand.vld && i_cand.used &&
                 (!r_found ||
                  (i_word.prio > r_word.prio) ||
                  ((i_word.prio == r_word.prio) && (i_word.seq < r_word.seq)));
    end

    // Found flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_clear) begin
            r_found <= 1'b0;
        end else if (better) begin
            r_found <= 1'b1;
        end
    end

    // Best slot index and contents.
    always_ff @(posedge i_clk) begin
        if (better && !i_clear) begin
            r_idx  <= i_cand.idx;
            r_word <= i_word;
        end
    end

    assign o_best.found = r_found;
    assign o_best.idx   = r_idx;
    assign o_best_word  = r_word;

endmodule

[rtl/core/priority_message_slot_queue_top.sv]
// ----------------------------------------------------------------------------
// Priority message slot queue
// Bounded message queue over a table of slots with priority-ordered receive.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken at a clock edge where start is high and busy is low.
//   i_cmd selects a send (store i_length, i_priority_req and i_payload) or a
//   receive (i_length is the caller's buffer capacity). Exactly one result
//   follows, shown on the o_ ports for one cycle while o_valid is high; the
//   receiver takes it in that cycle and cannot hold it off.
//   A command rejected by its checks (access, size, priority, full, empty)
//   reports in the cycle after the transfer. An accepted send walks the
//   slots from the lowest index for a free one, one slot per cycle, and
//   reports once it has stored the message or reached the capacity. An
//   accepted receive reads every slot once through the slot memory port
//   and the compare unit, one per cycle, and reports after the last compare.
//   The next command may be presented in the cycle its result is shown.
//   Configuration writes use i_cfg_valid/o_cfg_ready with a register index
//   and data; they are meant for an idle block. Reset (synchronous, active
//   low) empties the queue, restarts sequence numbering at one and loads the
//   registers with capacity 10, message size 8192 and read-write access.
// ----------------------------------------------------------------------------
module priority_message_slot_queue_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cmd,
    input  logic [16:0]                       i_length,
    input  logic [15:0]                       i_priority_req,
    input  logic [63:0]                       i_payload,
    output logic                              o_valid,
    output logic [2:0]                        o_status,
    output logic [14:0]                       o_out_priority,
    output logic [16:0]                       o_out_length,
    output logic [63:0]                       o_out_payload,
    output logic [8:0]                        o_message_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pmsq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pmsq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Configuration registers.
    logic [pmsq_pkg::CAPR_W-1:0]        r_max_messages;
    logic [pmsq_pkg::LEN_W-1:0]         r_message_size;
    logic [pmsq_pkg::MODE_W-1:0]        r_access_mode;

    // Sequencer and queue state.
    pmsq_pkg::t_state                   r_state, n_state;
    logic [pmsq_pkg::CNT_W-1:0]         r_ctr, n_ctr;
    logic [pmsq_pkg::SLOT_COUNT-1:0]    r_used, n_used;
    logic [pmsq_pkg::CNT_W-1:0]         r_count, n_count;
    logic [pmsq_pkg::SEQ_W-1:0]         r_next_seq, n_next_seq;

    // Command held during the scan.
    logic [pmsq_pkg::LEN_W-1:0]         r_len, n_len;
    logic [pmsq_pkg::PRIO_W-1:0]        r_prio, n_prio;
    logic [pmsq_pkg::PAYLOAD_BITS-1:0]  r_payload, n_payload;

    // Result registers.
    logic                               r_valid, n_valid;
    pmsq_pkg::t_status                  r_status, n_status;
    logic [pmsq_pkg::PRIO_W-1:0]        r_out_prio, n_out_prio;
    logic [pmsq_pkg::LEN_W-1:0]         r_out_len, n_out_len;
    logic [pmsq_pkg::PAYLOAD_BITS-1:0]  r_out_payload, n_out_payload;

    // Slot memory and compare unit connections.
    pmsq_pkg::t_cand                    r_cand, n_cand;
    logic                               wr_en;
    pmsq_pkg::t_slot_word               wr_data;
    pmsq_pkg::t_slot_word               rd_data;
    pmsq_pkg::t_best                    best;
    pmsq_pkg::t_slot_word               best_word;
    logic                               sel_clear;

    // Clamped configuration.
    logic [pmsq_pkg::CNT_W-1:0]         cap;
    logic [pmsq_pkg::LEN_W-1:0]         size_lim;
    logic [pmsq_pkg::IDX_W-1:0]         scan_idx;

    assign scan_idx = r_ctr[pmsq_pkg::IDX_W-1:0];

    // Configuration write channel; registers are always ready for a transfer.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_messages <= pmsq_pkg::CAP_RESET;
            r_message_size <= pmsq_pkg::SIZE_RESET;
            r_access_mode  <= pmsq_pkg::MODE_READ_WRITE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pmsq_pkg::CFG_MAX_MESSAGES: begin
                    r_max_messages <= i_cfg_data[pmsq_pkg::CAPR_W-1:0];
                end
                pmsq_pkg::CFG_MESSAGE_SIZE: begin
                    r_message_size <= i_cfg_data[pmsq_pkg::LEN_W-1:0];
                end
                pmsq_pkg::CFG_ACCESS_MODE: begin
                    r_access_mode <= i_cfg_data[pmsq_pkg::MODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Capacity and message size limited to their meaningful ranges.
    always_comb begin
        if (r_max_messages == '0) begin
            cap = pmsq_pkg::CNT_W'(1);
        end else if (32'(r_max_messages) > pmsq_pkg::SLOT_COUNT) begin
            cap = pmsq_pkg::SLOT_END;
        end else begin
            cap = pmsq_pkg::CNT_W'(r_max_messages);
        end

        if (r_message_size == '0) begin
            size_lim = pmsq_pkg::LEN_W'(1);
        end else if (32'(r_message_size) > pmsq_pkg::SIZE_LIMIT) begin
            size_lim = pmsq_pkg::LEN_W'(pmsq_pkg::SIZE_LIMIT);
        end else begin
            size_lim = r_message_size;
        end
    end

    // New slot contents for a send.
    assign wr_data.prio    = r_prio;
    assign wr_data.len     = r_len;
    assign wr_data.seq     = r_next_seq;
    assign wr_data.payload = r_payload;

    // Sequencer: checks, slot scans and result.
    always_comb begin
        n_state       = r_state;
        n_ctr         = r_ctr;
        n_used        = r_used;
        n_count       = r_count;
        n_next_seq    = r_next_seq;
        n_len         = r_len;
        n_prio        = r_prio;
        n_payload     = r_payload;
        n_valid       = 1'b0;
        n_status      = pmsq_pkg::STS_OK;
        n_out_prio    = '0;
        n_out_len     = '0;
        n_out_payload = '0;
        wr_en         = 1'b0;
        sel_clear     = 1'b0;

        n_cand.vld  = (r_state == pmsq_pkg::ST_RECV_SCAN) && (r_ctr < pmsq_pkg::SLOT_END);
        n_cand.used = r_used[scan_idx];
        n_cand.idx  = scan_idx;

        unique case (r_state)
            pmsq_pkg::ST_IDLE: begin
                if (start) begin
                    n_len     = i_length;
                    n_prio    = i_priority_req[pmsq_pkg::PRIO_W-1:0];
                    n_payload = i_payload[pmsq_pkg::PAYLOAD_BITS-1:0];
                    n_ctr     = '0;
                    if (i_cmd == pmsq_pkg::CMD_SEND) begin
                        priority if (r_access_mode == pmsq_pkg::MODE_READ_ONLY) begin
                            n_valid  = 1'b1;
                            n_status = pmsq_pkg::STS_ACCESS;
                        end else if (i_length > size_lim) begin
                            n_valid  = 1'b1;
                            n_status = pmsq_pkg::STS_SIZE;
                        end else if ({1'b0, i_priority_req} >=
                                     17'(pmsq_pkg::PRIORITY_LEVELS)) begin
                            n_valid  = 1'b1;
                            n_status = pmsq_pkg::STS_PRIORITY;
                        end else if (r_count >= cap) begin
                            n_valid  = 1'b1;
                            n_status = pmsq_pkg::STS_FULL;
                        end else begin
                            n_state = pmsq_pkg::ST_SEND_SCAN;
                        end
                    end else begin
                        priority if (r_access_mode == pmsq_pkg::MODE_WRITE_ONLY) begin
                            n_valid  = 1'b1;
                            n_status = pmsq_pkg::STS_ACCESS;
                        end else if (i_length < size_lim) begin
                            n_valid  = 1'b1;
                            n_status = pmsq_pkg::STS_SIZE;
                        end else if (r_count == '0) begin
                            n_valid  = 1'b1;
                            n_status = pmsq_pkg::STS_EMPTY;
                        end else begin
                            sel_clear = 1'b1;
                            n_state   = pmsq_pkg::ST_RECV_SCAN;
                        end
                    end
                end
            end

            pmsq_pkg::ST_SEND_SCAN: begin
                // Lowest free slot below the capacity takes the message.
                if (r_ctr >= cap) begin
                    n_valid  = 1'b1;
                    n_status = pmsq_pkg::STS_FULL;
                    n_state  = pmsq_pkg::ST_IDLE;
                end else if (!r_used[scan_idx]) begin
                    wr_en              = 1'b1;
                    n_used[scan_idx]   = 1'b1;
                    n_count            = r_count + pmsq_pkg::CNT_W'(1);
                    n_next_seq         = r_next_seq + pmsq_pkg::SEQ_W'(1);
                    n_valid            = 1'b1;
                    n_status           = pmsq_pkg::STS_OK;
                    n_state            = pmsq_pkg::ST_IDLE;
                end else begin
                    n_ctr = r_ctr + pmsq_pkg::CNT_W'(1);
                end
            end

            pmsq_pkg::ST_RECV_SCAN: begin
                // Reads are issued for every slot; the last compare lands
                // in the cycle after the last read address.
                if (r_ctr == pmsq_pkg::SLOT_END) begin
                    n_state = pmsq_pkg::ST_RECV_TAKE;
                end else begin
                    n_ctr = r_ctr + pmsq_pkg::CNT_W'(1);
                end
            end

            pmsq_pkg::ST_RECV_TAKE: begin
                n_valid = 1'b1;
                n_state = pmsq_pkg::ST_IDLE;
                if (best.found) begin
                    n_status         = pmsq_pkg::STS_OK;
                    n_out_prio       = best_word.prio;
                    n_out_len        = best_word.len;
                    n_out_payload    = best_word.payload;
                    n_used[best.idx] = 1'b0;
                    n_count          = r_count - pmsq_pkg::CNT_W'(1);
                end else begin
                    n_status = pmsq_pkg::STS_EMPTY;
                end
            end

            default: begin
                n_state = pmsq_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmsq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Queue bookkeeping, scan candidate and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_count    <= '0;
            r_next_seq <= pmsq_pkg::SEQ_W'(1);
            r_valid    <= 1'b0;
            r_cand     <= '0;
        end else begin
            r_used     <= n_used;
            r_count    <= n_count;
            r_next_seq <= n_next_seq;
            r_valid    <= n_valid;
            r_cand     <= n_cand;
        end
    end

    // Scan counter, held command and result registers.
    always_ff @(posedge i_clk) begin
        r_ctr         <= n_ctr;
        r_len         <= n_len;
        r_prio        <= n_prio;
        r_payload     <= n_payload;
        r_status      <= n_status;
        r_out_prio    <= n_out_prio;
        r_out_len     <= n_out_len;
        r_out_payload <= n_out_payload;
    end

    // Slot memory.
    pmsq_slot_ram u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (scan_idx),
        .i_wr_data (wr_data),
        .i_rd_addr (scan_idx),
        .o_rd_data (rd_data)
    );

    // Compare unit.
    pmsq_select u_select (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (sel_clear),
        .i_cand      (r_cand),
        .i_word      (rd_data),
        .o_best      (best),
        .o_best_word (best_word)
    );

    // Outputs.
    assign busy            = (r_state != pmsq_pkg::ST_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_out_priority  = 15'(r_out_prio);
    assign o_out_length    = r_out_len;
    assign o_out_payload   = 64'(r_out_payload);
    assign o_message_count = 9'(r_count);

    // The message count always matches the number of used slots.
    a_count_matches_used: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) == $countones(r_used)
    ) else $error("message count differs from used slot count");

    // The queue never holds more messages than it has slots.
    a_count_bounded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pmsq_pkg::SLOT_END
    ) else $error("message count above slot count");

    // An accepted command either starts a scan or reports at once.
    a_accept_progress: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid)
    ) else $error("accepted command neither scanned nor reported");

    // The slot chosen for a receive is a used slot.
    a_take_used: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pmsq_pkg::ST_RECV_TAKE && best.found) |-> r_used[best.idx]
    ) else $error("receive selected a free slot");

    // A send only writes a slot that was free.
    a_send_free: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !r_used[scan_idx]
    ) else $error("send overwrote a used slot");

endmodule

[dv/priority_message_slot_queue_checker.sv]
// ----------------------------------------------------------------------------
// Priority message slot queue checker
// Watches the command, result and register channels of the slot queue. It
// keeps its own copy of the slot table and registers, works out the reply to
// every accepted command and compares each result against the oldest reply.
// ----------------------------------------------------------------------------
module priority_message_slot_queue_checker
    import pmsq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic                  i_cmd,
    input  logic [16:0]           i_length,
    input  logic [15:0]           i_priority_req,
    input  logic [63:0]           i_payload,
    input  logic                  i_valid,
    input  logic [2:0]            i_status,
    input  logic [14:0]           i_out_priority,
    input  logic [16:0]           i_out_length,
    input  logic [63:0]           i_out_payload,
    input  logic [8:0]            i_message_count,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_failures
);
    timeunit 1ns;
    timeprecision 1ps;

    // One reply of the queue as it should appear on the result ports.
    typedef struct {
        t_status     status;
        logic [14:0] prio;
        logic [16:0] len;
        logic [63:0] payload;
        logic [8:0]  count;
    } t_reply;

    // Shadow copy of the slot table and the registers.
    logic                    slot_taken [SLOT_COUNT];
    logic [PRIO_W-1:0]       slot_rank  [SLOT_COUNT];
    logic [LEN_W-1:0]        slot_len   [SLOT_COUNT];
    logic [SEQ_W-1:0]        slot_order [SLOT_COUNT];
    logic [PAYLOAD_BITS-1:0] slot_word  [SLOT_COUNT];
    logic [SEQ_W-1:0]        order_next;
    int unsigned             occupancy;
    logic [CAPR_W-1:0]       cfg_capacity;
    logic [LEN_W-1:0]        cfg_size;
    logic [MODE_W-1:0]       cfg_mode;

    t_reply reply_q[$];
    int     fail_count = 0;

    assign o_failures = fail_count;

    // Applies one command to the shadow table and returns the reply it earns.
    function automatic t_reply serve_command(input t_cmd cmd, input logic [16:0] len,
                                             input logic [15:0] prio,
                                             input logic [63:0] data);
        t_reply      r;
        int unsigned cap_lim;
        int unsigned size_lim;
        int unsigned pick;
        bit          found;
        int          i;
        r.status  = STS_OK;
        r.prio    = '0;
        r.len     = '0;
        r.payload = '0;
        cap_lim   = (cfg_capacity == 0) ? 1 : cfg_capacity;
        if (cap_lim > SLOT_COUNT) cap_lim = SLOT_COUNT;
        size_lim  = (cfg_size == 0) ? 1 : cfg_size;
        if (size_lim > SIZE_LIMIT) size_lim = SIZE_LIMIT;
        found     = 1'b0;
        pick      = 0;
        if (cmd == CMD_SEND) begin
            if (cfg_mode == MODE_READ_ONLY) begin
                r.status = STS_ACCESS;
            end else if (len > size_lim) begin
                r.status = STS_SIZE;
            end else if (prio >= PRIORITY_LEVELS) begin
                r.status = STS_PRIORITY;
            end else if (occupancy >= cap_lim) begin
                r.status = STS_FULL;
            end else begin
                // Lowest free slot below the capacity takes the message.
                for (i = 0; i < cap_lim && !found; i++) begin
                    if (!slot_taken[i]) begin
                        slot_taken[i] = 1'b1;
                        slot_rank[i]  = prio[PRIO_W-1:0];
                        slot_len[i]   = len;
                        slot_order[i] = order_next;
                        slot_word[i]  = data[PAYLOAD_BITS-1:0];
                        order_next    = order_next + 1'b1;
                        occupancy     = occupancy + 1;
                        found         = 1'b1;
                    end
                end
                if (!found) r.status = STS_FULL;
            end
        end else begin
            if (cfg_mode == MODE_WRITE_ONLY) begin
                r.status = STS_ACCESS;
            end else if (len < size_lim) begin
                r.status = STS_SIZE;
            end else if (occupancy == 0) begin
                r.status = STS_EMPTY;
            end else begin
                // Highest priority wins; the oldest message breaks a tie.
                for (i = 0; i < SLOT_COUNT; i++) begin
                    if (slot_taken[i] && (!found || slot_rank[i] > slot_rank[pick] ||
                        (slot_rank[i] == slot_rank[pick] &&
                         slot_order[i] < slot_order[pick]))) begin
                        pick  = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = STS_EMPTY;
                end else begin
                    r.prio            = slot_rank[pick];
                    r.len             = slot_len[pick];
                    r.payload         = 64'(slot_word[pick]);
                    slot_taken[pick]  = 1'b0;
                    occupancy         = occupancy - 1;
                end
            end
        end
        r.count = occupancy[8:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Register writes, reply prediction and result comparison.
    always @(posedge i_clk) begin
        t_reply want;
        int     i;
        if (!i_rst_n) begin
            for (i = 0; i < SLOT_COUNT; i++) slot_taken[i] = 1'b0;
            order_next   = 1;
            occupancy    = 0;
            cfg_capacity = CAP_RESET;
            cfg_size     = SIZE_RESET;
            cfg_mode     = MODE_READ_WRITE;
            reply_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_MAX_MESSAGES: cfg_capacity = i_cfg_data[CAPR_W-1:0];
                    CFG_MESSAGE_SIZE: cfg_size     = i_cfg_data[LEN_W-1:0];
                    CFG_ACCESS_MODE:  cfg_mode     = i_cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end
            // A shown result belongs to an earlier command, so compare first.
            if (i_valid) begin
                if (reply_q.size() == 0) begin
                    $error("result shown with no command outstanding");
                    fail_count++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("status", 64'(want.status), 64'(i_status));
                    check_field("out_priority", 64'(want.prio), 64'(i_out_priority));
                    check_field("out_length", 64'(want.len), 64'(i_out_length));
                    check_field("out_payload", want.payload, i_out_payload);
                    check_field("message_count", 64'(want.count), 64'(i_message_count));
                end
            end
            if (i_start && !i_busy) begin
                reply_q.push_back(serve_command(t_cmd'(i_cmd), i_length,
                                                i_priority_req, i_payload));
            end
        end
        o_pending <= reply_q.size();
    end

endmodule

[dv/priority_message_slot_queue_top_tb.sv]
// ----------------------------------------------------------------------------
// Priority message slot queue testbench
// Drives sends and receives into the slot queue under a series of register
// settings: a directed opening over the checks and corner cases, then random
// phases that fill the table to capacity, drain it, shrink the capacity and
// message size under load and restrict access. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module priority_message_slot_queue_top_tb;
    import pmsq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int              CYCLE_LIMIT   = 1_000_000;
    // Access mode three behaves as read and write.
    localparam logic [MODE_W-1:0] MODE_ALIAS_RW = 2'd3;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic                  busy;
    logic                  i_cmd          = CMD_SEND;
    logic [16:0]           i_length       = '0;
    logic [15:0]           i_priority_req = '0;
    logic [63:0]           i_payload      = '0;
    logic                  o_valid;
    logic [2:0]            o_status;
    logic [14:0]           o_out_priority;
    logic [16:0]           o_out_length;
    logic [63:0]           o_out_payload;
    logic [8:0]            o_message_count;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = CFG_MAX_MESSAGES;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    int          pending;
    int          failures;
    int          cycle_count = 0;
    int unsigned size_now    = SIZE_RESET;
    bit          gaps_on     = 1'b1;

    // Clock: 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    priority_message_slot_queue_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_length        (i_length),
        .i_priority_req  (i_priority_req),
        .i_payload       (i_payload),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_out_priority  (o_out_priority),
        .o_out_length    (o_out_length),
        .o_out_payload   (o_out_payload),
        .o_message_count (o_message_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    priority_message_slot_queue_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_cmd           (i_cmd),
        .i_length        (i_length),
        .i_priority_req  (i_priority_req),
        .i_payload       (i_payload),
        .i_valid         (o_valid),
        .i_status        (o_status),
        .i_out_priority  (o_out_priority),
        .i_out_length    (o_out_length),
        .i_out_payload   (o_out_payload),
        .i_message_count (o_message_count),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_pending       (pending),
        .o_failures      (failures)
    );

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("priority_message_slot_queue_top_tb: done, errors");
            $finish;
        end
    end

    // Presents one command and returns at the edge of its transfer. The start
    // line stays high afterward so back-to-back commands need no extra edge.
    task automatic push_command(input t_cmd c, input logic [16:0] len,
                                input logic [15:0] pr, input logic [63:0] pl);
        if (gaps_on && $urandom_range(99) < 25) begin
            start <= 1'b0;
            @(posedge i_clk);
            if ($urandom_range(1) == 1) begin
                while (busy) @(posedge i_clk);
            end
            repeat ($urandom_range(2, 0)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_cmd          <= c;
        i_length       <= len;
        i_priority_req <= pr;
        i_payload      <= pl;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Holds off until every outstanding result has come back and the block
    // is idle.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Writes all three registers on an idle block.
    task automatic set_config(input logic [8:0] cap, input logic [16:0] size,
                              input logic [1:0] mode);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MAX_MESSAGES;
        i_cfg_data  <= 17'(cap);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_MESSAGE_SIZE;
        i_cfg_data  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_ACCESS_MODE;
        i_cfg_data  <= 17'(mode);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        size_now = (size == 0) ? 1 : size;
        if (size_now > SIZE_LIMIT) size_now = SIZE_LIMIT;
    endtask

    // One random phase: mostly well-formed traffic with a share of rejects.
    task automatic run_phase(input logic [8:0] cap, input logic [16:0] size,
                             input logic [1:0] mode, input int count,
                             input int send_pct, input int bad_pct);
        t_cmd        c;
        logic [16:0] len;
        logic [15:0] pr;
        logic [63:0] pl;
        int          roll;
        set_config(cap, size, mode);
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            pl   = {$urandom, $urandom};
            pr   = ($urandom_range(1) == 1) ? 16'($urandom_range(3))
                                            : 16'($urandom_range(PRIORITY_LEVELS - 1));
            if ($urandom_range(99) < send_pct) begin
                c   = CMD_SEND;
                len = ($urandom_range(4) == 0) ? 17'(size_now)
                                               : 17'($urandom_range(size_now));
                if (roll < bad_pct / 2 && size_now < SIZE_LIMIT) begin
                    len = 17'($urandom_range(SIZE_LIMIT, size_now + 1));
                end else if (roll < bad_pct) begin
                    pr = 16'($urandom_range(65535, PRIORITY_LEVELS));
                end
            end else begin
                c   = CMD_RECEIVE;
                len = 17'($urandom_range(SIZE_LIMIT, size_now));
                if (roll < bad_pct && size_now > 1) begin
                    len = 17'($urandom_range(size_now - 1));
                end
            end
            push_command(c, len, pr, pl);
            // Occasionally let the queue run dry of outstanding results.
            if (gaps_on && $urandom_range(99) < 2) settle();
        end
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: capacity 10, message size 8192, read and write.
        push_command(CMD_RECEIVE, 17'd8192, 16'd0, 64'd0);
        push_command(CMD_RECEIVE, 17'd8191, 16'd0, 64'd0);
        push_command(CMD_SEND, 17'd8193, 16'd1, 64'd1);
        push_command(CMD_SEND, 17'd0, 16'd32768, 64'd2);
        push_command(CMD_SEND, 17'd0, 16'hFFFF, 64'd3);
        push_command(CMD_SEND, 17'd0, 16'd0, 64'd0);
        push_command(CMD_SEND, 17'd8192, 16'd32767, '1);
        push_command(CMD_SEND, 17'd5, 16'd32767, {$urandom, $urandom});
        push_command(CMD_SEND, 17'd1, 16'd7, {$urandom, $urandom});
        push_command(CMD_RECEIVE, 17'd65536, 16'd0, 64'd0);
        push_command(CMD_RECEIVE, 17'd8192, 16'd0, 64'd0);

        // Fill to capacity with long messages, then one more is turned away.
        for (int n = 0; n < 9; n++) begin
            push_command(CMD_SEND, 17'd8192, 16'($urandom_range(3)), {$urandom, $urandom});
        end

        // Capacity and size shrunk under load; long messages still come out.
        set_config(9'd0, 17'd0, MODE_ALIAS_RW);
        push_command(CMD_SEND, 17'd0, 16'd0, 64'd4);
        push_command(CMD_RECEIVE, 17'd1, 16'd0, 64'd0);
        set_config(9'd0, 17'd0, MODE_READ_ONLY);
        push_command(CMD_SEND, 17'd1, 16'd0, 64'd5);
        push_command(CMD_RECEIVE, 17'd0, 16'd0, 64'd0);
        set_config(9'd0, 17'd0, MODE_WRITE_ONLY);
        push_command(CMD_RECEIVE, 17'd65536, 16'd0, 64'd0);
        push_command(CMD_SEND, 17'd1, 16'd0, 64'd6);

        // Random phases: fill all slots, then drain through a small capacity.
        run_phase(9'd256, 17'd65536, MODE_READ_WRITE, 275, 99, 0);
        run_phase(9'd4, 17'h1FFFF, MODE_ALIAS_RW, 280, 5, 12);
        run_phase(9'd511, 17'd1, MODE_READ_WRITE, 40, 50, 12);
        run_phase(9'($urandom_range(12, 1)), 17'($urandom_range(SIZE_LIMIT, 1)),
                  MODE_READ_WRITE, 40, 50, 12);
        run_phase(9'd0, 17'd0, MODE_READ_WRITE, 30, 50, 12);
        run_phase(9'($urandom_range(16, 1)), 17'($urandom_range(SIZE_LIMIT, 1)),
                  MODE_WRITE_ONLY, 20, 60, 12);
        run_phase(9'($urandom_range(16, 2)), 17'($urandom_range(SIZE_LIMIT, 1)),
                  MODE_READ_ONLY, 20, 40, 12);
        gaps_on = 1'b0;
        run_phase(9'd6, 17'd300, MODE_READ_WRITE, 40, 55, 12);

        // Drain, then watch a full receive time for stray results.
        settle();
        repeat (SLOT_COUNT + 8) @(posedge i_clk);
        if (failures == 0) begin
            $display("priority_message_slot_queue_top_tb: done, clean");
        end else begin
            $display("priority_message_slot_queue_top_tb: done, errors");
        end
        $finish;
    end

endmodule
